>>> rtl/reliable_datagram_channel_assert.svh
// Assertion macros shared by the datagram channel modules
`ifndef RELIABLE_DATAGRAM_CHANNEL_ASSERT_SVH
`define RELIABLE_DATAGRAM_CHANNEL_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication, clocked on i_clk, off during reset
`define RDC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rdc assertion failed");
// next-cycle implication
`define RDC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rdc assertion failed");
`else
`define RDC_ASSERT_NOW(lbl, ante, cons)
`define RDC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> rtl/rdc_pkg.sv
// Shared types and constants of the reliable datagram channel
package rdc_pkg;

    localparam int SEQ_W      = 31;
    localparam int CNT_W      = 32;
    localparam int TIME_W     = 32;
    localparam int LEN_IN_W   = 12;
    localparam int BT_W       = 10;
    localparam int HDR_BYTES  = 8;
    localparam int BYTE_TIME_RESET = 400;

    typedef logic [2:0] t_opcode;
    localparam t_opcode OP_CAN_SEND = 3'd0;
    localparam t_opcode OP_CAN_REL  = 3'd1;
    localparam t_opcode OP_XMIT     = 3'd2;
    localparam t_opcode OP_RECV     = 3'd3;
    localparam t_opcode OP_OPEN     = 3'd4;

    // register index of byte_time
    localparam logic REG_BYTE_TIME = 1'b0;

    typedef struct packed {
        t_opcode             opcode;
        logic [TIME_W-1:0]   current_time;
        logic [LEN_IN_W-1:0] pending_len;
        logic                pending_overflowed;
        logic [31:0]         recv_seq_word;
        logic [31:0]         recv_ack_word;
    } t_item;

    typedef struct packed {
        logic                ok;
        logic                fatal;
        logic [31:0]         send_seq_word;
        logic [31:0]         send_ack_word;
        logic                promote_pending;
        logic                reliable_included;
        logic                append_pending;
        logic [LEN_IN_W-1:0] packet_len;
        logic [CNT_W-1:0]    choke_total;
        logic [CNT_W-1:0]    drop_total;
        logic [CNT_W-1:0]    good_total;
    } t_result;

endpackage

>>> rtl/rdc_cfg.sv
// Configuration register file: byte_time and its backlog product
module rdc_cfg
    import rdc_pkg::*;
#(
    parameter int BACKLOG_BYTES = 200,
    parameter int BL_W          = 22
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [2:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready,
    output logic [BT_W-1:0] o_byte_time,
    output logic [BL_W-1:0] o_backlog_time
);

    logic [BT_W-1:0] r_byte_time;
    logic [BL_W-1:0] r_backlog_time;
    logic            n_wr;
    logic [BL_W-1:0] n_backlog_time;

    assign pready         = 1'b1;
    assign n_wr           = psel && penable && pwrite && (paddr[2] == REG_BYTE_TIME);
    // keep the backlog product ready so the choke test needs only an add
    assign n_backlog_time = BL_W'(BACKLOG_BYTES * pwdata[BT_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_time    <= BT_W'(BYTE_TIME_RESET);
            r_backlog_time <= BL_W'(BACKLOG_BYTES * BYTE_TIME_RESET);
        end else if (n_wr) begin
            r_byte_time    <= pwdata[BT_W-1:0];
            r_backlog_time <= n_backlog_time;
        end
    end

    assign prdata         = (paddr[2] == REG_BYTE_TIME) ? 32'(r_byte_time) : 32'd0;
    assign o_byte_time    = r_byte_time;
    assign o_backlog_time = r_backlog_time;

endmodule

>>> rtl/rdc_core.sv
// Channel state and the per-word sequencing, choke and header logic
module rdc_core
    import rdc_pkg::*;
#(
    parameter int MAX_PACKET_BYTES = 2048,
    parameter int BL_W             = 22
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_adv,
    input  t_item           i_item,
    input  logic [BT_W-1:0] i_byte_time,
    input  logic [BL_W-1:0] i_backlog_time,
    output t_result         o_result
);
    `include "reliable_datagram_channel_assert.svh"

    // length sum width: header plus two 12-bit runs plus the packet limit
    localparam int LEN_W  = $clog2(MAX_PACKET_BYTES + HDR_BYTES + 2 * (1 << LEN_IN_W) + 1);
    localparam int PROD_W = LEN_W + BT_W;

    logic [SEQ_W-1:0]    r_out_seq, r_in_seq, r_in_acked_seq, r_last_rel_seq;
    logic                r_out_rel_flag, r_in_rel_flag, r_in_rel_acked, r_fatal;
    logic [LEN_IN_W-1:0] r_rel_len;
    logic [TIME_W-1:0]   r_clear_time;
    logic [CNT_W-1:0]    r_drop_cnt, r_good_cnt, r_choke_cnt;

    logic [SEQ_W-1:0]    n_out_seq, n_in_seq, n_in_acked_seq, n_last_rel_seq;
    logic                n_out_rel_flag, n_in_rel_flag, n_in_rel_acked, n_fatal;
    logic [LEN_IN_W-1:0] n_rel_len;
    logic [TIME_W-1:0]   n_clear_time;
    logic [CNT_W-1:0]    n_drop_cnt, n_good_cnt, n_choke_cnt;

    logic                n_rate_ok, n_bad, n_resend, n_promote, n_srel, n_app;
    logic [TIME_W:0]     n_limit, n_credit;
    logic [LEN_W-1:0]    n_pend, n_pend_left, n_len_hdr, n_len;
    logic [LEN_IN_W-1:0] n_rel_eff;
    logic [TIME_W-1:0]   n_base;
    logic [PROD_W-1:0]   n_prod;
    logic [SEQ_W-1:0]    n_rx_seq, n_rx_ack;
    logic                n_rx_new, n_rx_gap, n_rx_clear;

    always_comb begin
        // rate choke against the backlog limit, without wrap
        n_limit   = {1'b0, i_item.current_time} + (TIME_W+1)'(i_backlog_time);
        n_rate_ok = {1'b0, r_clear_time} < n_limit;

        // transmit
        n_pend    = LEN_W'(i_item.pending_len);
        n_bad     = i_item.pending_overflowed ||
                    (n_pend > LEN_W'(MAX_PACKET_BYTES - HDR_BYTES));
        n_resend  = (r_in_acked_seq > r_last_rel_seq) && (r_in_rel_acked != r_out_rel_flag);
        n_promote = (r_rel_len == '0) && (i_item.pending_len != '0);
        n_srel    = n_resend || n_promote;
        n_rel_eff = n_promote ? i_item.pending_len : r_rel_len;
        n_pend_left = n_promote ? '0 : n_pend;
        n_len_hdr = LEN_W'(HDR_BYTES) + (n_srel ? LEN_W'(n_rel_eff) : '0);
        n_app     = (n_pend_left != '0) &&
                    ((n_len_hdr + n_pend_left) <= LEN_W'(MAX_PACKET_BYTES));
        n_len     = n_len_hdr + (n_app ? n_pend_left : '0);
        n_base    = (r_clear_time < i_item.current_time) ? i_item.current_time : r_clear_time;
        n_prod    = PROD_W'(n_len) * PROD_W'(i_byte_time);
        n_credit  = {1'b0, n_base} + (TIME_W+1)'(n_prod);

        // receive
        n_rx_seq   = i_item.recv_seq_word[SEQ_W-1:0];
        n_rx_ack   = i_item.recv_ack_word[SEQ_W-1:0];
        n_rx_new   = n_rx_seq > r_in_seq;
        n_rx_gap   = {1'b0, n_rx_seq} > ({1'b0, r_in_seq} + (SEQ_W+1)'(1));
        n_rx_clear = (i_item.recv_ack_word[31] == r_out_rel_flag) ||
                     (n_rx_ack > r_last_rel_seq);

        n_out_seq      = r_out_seq;
        n_in_seq       = r_in_seq;
        n_in_acked_seq = r_in_acked_seq;
        n_last_rel_seq = r_last_rel_seq;
        n_out_rel_flag = r_out_rel_flag;
        n_in_rel_flag  = r_in_rel_flag;
        n_in_rel_acked = r_in_rel_acked;
        n_fatal        = r_fatal;
        n_rel_len      = r_rel_len;
        n_clear_time   = r_clear_time;
        n_drop_cnt     = r_drop_cnt;
        n_good_cnt     = r_good_cnt;
        n_choke_cnt    = r_choke_cnt;
        o_result       = '0;

        unique case (i_item.opcode)
            OP_CAN_SEND: begin
                o_result.ok = n_rate_ok;
                if (!n_rate_ok) n_choke_cnt = r_choke_cnt + CNT_W'(1);
            end
            OP_CAN_REL: begin
                if (r_rel_len == '0) begin
                    o_result.ok = n_rate_ok;
                    if (!n_rate_ok) n_choke_cnt = r_choke_cnt + CNT_W'(1);
                end
            end
            OP_XMIT: begin
                if (n_bad) begin
                    n_fatal = 1'b1;
                end else begin
                    o_result.ok                = 1'b1;
                    o_result.send_seq_word     = {n_srel, r_out_seq};
                    o_result.send_ack_word     = {r_in_rel_flag, r_in_seq};
                    o_result.promote_pending   = n_promote;
                    o_result.reliable_included = n_srel;
                    o_result.append_pending    = n_app;
                    o_result.packet_len        = n_len[LEN_IN_W-1:0];
                    n_rel_len = n_rel_eff;
                    if (n_srel) begin
                        n_last_rel_seq = r_out_seq;
                        n_out_rel_flag = 1'b1;
                    end
                    n_out_seq    = r_out_seq + SEQ_W'(1);
                    // saturate the credit at all ones
                    n_clear_time = n_credit[TIME_W] ? '1 : n_credit[TIME_W-1:0];
                end
            end
            OP_RECV: begin
                if (n_rx_new) begin
                    if (n_rx_gap) n_drop_cnt = r_drop_cnt + CNT_W'(1);
                    if (n_rx_clear) begin
                        n_rel_len      = '0;
                        n_out_rel_flag = 1'b0;
                    end
                    n_in_seq       = n_rx_seq;
                    n_in_acked_seq = n_rx_ack;
                    n_in_rel_flag  = i_item.recv_seq_word[31];
                    n_in_rel_acked = i_item.recv_ack_word[31];
                    n_good_cnt     = r_good_cnt + CNT_W'(1);
                    o_result.ok    = 1'b1;
                end
            end
            OP_OPEN: begin
                n_out_seq      = SEQ_W'(1);
                n_in_seq       = '0;
                n_in_acked_seq = '0;
                n_last_rel_seq = '0;
                n_out_rel_flag = 1'b0;
                n_in_rel_flag  = 1'b0;
                n_in_rel_acked = 1'b1;
                n_fatal        = 1'b0;
                n_rel_len      = '0;
                n_clear_time   = '0;
                n_drop_cnt     = '0;
                n_good_cnt     = '0;
                n_choke_cnt    = '0;
                o_result.ok    = 1'b1;
            end
            default: begin
            end
        endcase

        o_result.fatal       = n_fatal;
        o_result.choke_total = n_choke_cnt;
        o_result.drop_total  = n_drop_cnt;
        o_result.good_total  = n_good_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_seq      <= '0;
            r_in_seq       <= '0;
            r_in_acked_seq <= '0;
            r_last_rel_seq <= '0;
            r_out_rel_flag <= 1'b0;
            r_in_rel_flag  <= 1'b0;
            r_in_rel_acked <= 1'b0;
            r_fatal        <= 1'b0;
            r_rel_len      <= '0;
            r_clear_time   <= '0;
            r_drop_cnt     <= '0;
            r_good_cnt     <= '0;
            r_choke_cnt    <= '0;
        end else if (i_adv) begin
            r_out_seq      <= n_out_seq;
            r_in_seq       <= n_in_seq;
            r_in_acked_seq <= n_in_acked_seq;
            r_last_rel_seq <= n_last_rel_seq;
            r_out_rel_flag <= n_out_rel_flag;
            r_in_rel_flag  <= n_in_rel_flag;
            r_in_rel_acked <= n_in_rel_acked;
            r_fatal        <= n_fatal;
            r_rel_len      <= n_rel_len;
            r_clear_time   <= n_clear_time;
            r_drop_cnt     <= n_drop_cnt;
            r_good_cnt     <= n_good_cnt;
            r_choke_cnt    <= n_choke_cnt;
        end
    end

    `RDC_ASSERT_NEXT(a_open_state, i_adv && (i_item.opcode == OP_OPEN),
        (r_out_seq == SEQ_W'(1)) && !r_fatal && r_in_rel_acked && (r_rel_len == '0))
    `RDC_ASSERT_NEXT(a_xmit_seq, i_adv && (i_item.opcode == OP_XMIT) && !n_bad,
        r_out_seq == SEQ_W'($past(r_out_seq) + SEQ_W'(1)))
    `RDC_ASSERT_NOW(a_promote_sets_rel, o_result.promote_pending,
        o_result.reliable_included && o_result.send_seq_word[31])
    `RDC_ASSERT_NEXT(a_idle_holds, !i_adv,
        $stable(r_out_seq) && $stable(r_clear_time) && $stable(r_good_cnt))

endmodule

>>> rtl/reliable_datagram_channel.sv
// Reliable datagram channel: control side of a sequenced datagram link
// Slave stream: one word per request; tuser carries the opcode (can send,
// can send reliable, transmit, receive header, open), tdata the time,
// pending buffer state and received header words. Master stream: one
// result word per request with the ok flag, fatal flag, both transmit
// header words, promote / reliable / append flags, packet length and the
// choke, drop and good counters.
// APB port: byte_time at address 0 (reads back); write only while idle.
// Path: input register, then the core, then the result register on the
// master side. Throughput: one word per cycle while results are taken;
// the state update of a word (sequence, credit, counters) is combinational
// between the input register and the result register.
// Stall: the input register takes a new word while a result waits, so the
// block holds at most two words; tready drops only when both are full.
// Reset: the channel state clears, byte_time returns to 400; an open
// request then sets the outgoing sequence to one.
module reliable_datagram_channel
    import rdc_pkg::*;
#(
    parameter int MAX_PACKET_BYTES = 2048,
    parameter int BACKLOG_BYTES    = 200
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // [31:0] current_time, [43:32] pending_len, [44] pending_overflowed,
    // [76:45] recv_seq_word, [108:77] recv_ack_word, [111:109] zero
    input  logic [111:0]  s_axis_tdata,
    // [2:0] opcode
    input  logic [2:0]    s_axis_tuser,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // [0] ok, [1] fatal, [33:2] send_seq_word, [65:34] send_ack_word,
    // [66] promote_pending, [67] reliable_included, [68] append_pending,
    // [80:69] packet_len, [112:81] choke_total, [144:113] drop_total,
    // [176:145] good_total, [183:177] zero
    output logic [183:0]  m_axis_tdata,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);
    `include "reliable_datagram_channel_assert.svh"

    localparam int BL_W = $clog2(BACKLOG_BYTES * ((1 << BT_W) - 1) + 1);

    logic            r_in_valid, r_out_valid;
    t_item           r_item;
    t_result         r_res;
    t_item           n_item;
    t_result         n_res;
    logic            n_adv;
    logic [BT_W-1:0] n_byte_time;
    logic [BL_W-1:0] n_backlog_time;

    assign n_item.opcode             = s_axis_tuser;
    assign n_item.current_time       = s_axis_tdata[31:0];
    assign n_item.pending_len        = s_axis_tdata[43:32];
    assign n_item.pending_overflowed = s_axis_tdata[44];
    assign n_item.recv_seq_word      = s_axis_tdata[76:45];
    assign n_item.recv_ack_word      = s_axis_tdata[108:77];

    // advance the held word whenever the result register is free or draining
    assign n_adv         = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || n_adv;

    rdc_cfg #(
        .BACKLOG_BYTES (BACKLOG_BYTES),
        .BL_W          (BL_W)
    ) u_cfg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_byte_time    (n_byte_time),
        .o_backlog_time (n_backlog_time)
    );

    rdc_core #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES),
        .BL_W             (BL_W)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_adv          (n_adv),
        .i_item         (r_item),
        .i_byte_time    (n_byte_time),
        .i_backlog_time (n_backlog_time),
        .o_result       (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) r_in_valid <= 1'b1;
            else if (n_adv)                     r_in_valid <= 1'b0;
            if (n_adv)              r_out_valid <= 1'b1;
            else if (m_axis_tready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) r_item <= n_item;
        if (n_adv)                          r_res  <= n_res;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0,
                            r_res.good_total,
                            r_res.drop_total,
                            r_res.choke_total,
                            r_res.packet_len,
                            r_res.append_pending,
                            r_res.reliable_included,
                            r_res.promote_pending,
                            r_res.send_ack_word,
                            r_res.send_seq_word,
                            r_res.fatal,
                            r_res.ok};

    `RDC_ASSERT_NEXT(a_result_kept, r_out_valid && !m_axis_tready, r_out_valid)
    `RDC_ASSERT_NOW(a_ready_when_empty, !r_in_valid, s_axis_tready)
    `RDC_ASSERT_NEXT(a_adv_fills_out, n_adv, r_out_valid)

endmodule
